// File: design/gn2d_pkg.sv
// shared constants and the sine lookup for the gradient noise block
package gn2d_pkg;

   localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
   localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;
   localparam logic [7:0]  COS_PHASE = 8'd64;
   localparam logic signed [17:0] ONE_Q16 = 18'sd65536;
   localparam int CORNER_LATENCY = 8;
   localparam int FADE_LATENCY = 8;

   typedef logic [15:0] qsine_row_type [0:64];

   localparam qsine_row_type QUARTER_SINE = '{
      16'd0, 16'd401, 16'd804, 16'd1206, 16'd1606, 16'd2005, 16'd2404, 16'd2802,
      16'd3197, 16'd3590, 16'd3981, 16'd4370, 16'd4756, 16'd5140, 16'd5520, 16'd5897,
      16'd6270, 16'd6639, 16'd7006, 16'd7366, 16'd7723, 16'd8076, 16'd8423, 16'd8765,
      16'd9103, 16'd9434, 16'd9760, 16'd10079, 16'd10394, 16'd10702, 16'd11004,
      16'd11297, 16'd11585, 16'd11865, 16'd12141, 16'd12406, 16'd12665, 16'd12916,
      16'd13160, 16'd13396, 16'd13623, 16'd13843, 16'd14053, 16'd14256, 16'd14449,
      16'd14634, 16'd14811, 16'd14978, 16'd15137, 16'd15286, 16'd15426, 16'd15557,
      16'd15678, 16'd15791, 16'd15892, 16'd15986, 16'd16069, 16'd16143, 16'd16207,
      16'd16261, 16'd16305, 16'd16340, 16'd16364, 16'd16379, 16'd16384
   };

   // full-circle sine in q2.14 from the quarter wave
   function automatic logic signed [15:0] sine_lookup(input logic [7:0] idx);
      logic [15:0] mag;
      if (idx <= 8'd64) begin
         mag = QUARTER_SINE[7'(idx)];
      end else if (idx <= 8'd128) begin
         mag = QUARTER_SINE[7'(8'd128 - idx)];
      end else if (idx <= 8'd192) begin
         mag = QUARTER_SINE[7'(idx - 8'd128)];
      end else begin
         mag = QUARTER_SINE[7'(9'd256 - {1'b0, idx})];
      end
      if (idx > 8'd128) begin
         sine_lookup = -$signed(mag);
      end else begin
         sine_lookup = $signed(mag);
      end
   endfunction

endpackage

// File: design/gn2d_corner.sv
// one lattice corner: hash, gradient lookup and dot product with the offset
module gn2d_corner
   import gn2d_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        cx,
   input  logic [31:0]        cy,
   input  logic signed [17:0] dx,
   input  logic signed [17:0] dy,
   output logic signed [33:0] dot
);

   logic [31:0] t_ff, m1_ff, m2_ff, m3_ff, m4_ff;
   logic [31:0] t_in, m1_in, m2_in, m3_in, m4_in;
   logic [31:0] nx, a1, b1, a2, b2, h;
   logic signed [15:0] gx_ff, gy_ff, gx_in, gy_in;
   logic signed [32:0] px_ff, py_ff, px_in, py_in;
   logic signed [33:0] dot_ff, dot_in;
   logic signed [17:0] dx_ff [0:5];
   logic signed [17:0] dy_ff [0:5];

   always_comb begin
      nx    = ~(cx << cy[1:0]);
      t_in  = cx ^ 32'(nx * cy);
      a1    = t_ff ^ (t_ff >> 16);
      m1_in = 32'(a1 * MIX_MUL_A);
      b1    = m1_ff ^ (m1_ff >> 15);
      m2_in = 32'(b1 * MIX_MUL_B);
      // end of first mix, start of the second
      a2    = (m2_ff ^ (m2_ff >> 16));
      a2    = a2 ^ (a2 >> 16);
      m3_in = 32'(a2 * MIX_MUL_A);
      b2    = m3_ff ^ (m3_ff >> 15);
      m4_in = 32'(b2 * MIX_MUL_B);
      h     = m4_ff ^ (m4_ff >> 16);
      gy_in = sine_lookup(h[7:0]);
      gx_in = sine_lookup(8'(COS_PHASE - h[7:0]));
      px_in = 33'(dx_ff[5] * gx_ff);
      py_in = 33'(dy_ff[5] * gy_ff);
      dot_in = 34'(px_ff) + 34'(py_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff   <= t_in;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         m3_ff  <= m3_in;
         m4_ff  <= m4_in;
         gx_ff  <= gx_in;
         gy_ff  <= gy_in;
         px_ff  <= px_in;
         py_ff  <= py_in;
         dot_ff <= dot_in;
         dx_ff[0] <= dx;
         dy_ff[0] <= dy;
         for (int i = 1; i < 6; i++) begin
            dx_ff[i] <= dx_ff[i-1];
            dy_ff[i] <= dy_ff[i-1];
         end
      end
   end

   assign dot = dot_ff;

endmodule

// File: design/gn2d_fade.sv
// quintic fade curve in q0.16, delayed to line up with the corner dots
module gn2d_fade
   import gn2d_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [15:0]        w,
   output logic signed [17:0] f
);

   localparam int DELAY = FADE_LATENCY - 3;

   logic signed [17:0] ws, w1_ff, w1_in;
   logic signed [17:0] w2_ff, w2_in, w3_ff, w3_in, f_ff, f_in;
   logic signed [21:0] p_ff, p_ff2, p_in, t6;
   logic signed [37:0] wt;
   logic signed [39:0] fp;
   logic signed [35:0] sq, cb;
   logic signed [17:0] dly_ff [0:DELAY-1];

   always_comb begin
      ws    = $signed({2'b00, w});
      sq    = 36'(ws * ws);
      w2_in = 18'(sq >>> 16);
      t6    = 22'(ws) * 22'sd6 - 22'sd983040;
      wt    = 38'(ws * t6);
      p_in  = 22'(wt >>> 16) + 22'sd655360;
      w1_in = ws;
      cb    = 36'(w2_ff * w1_ff);
      w3_in = 18'(cb >>> 16);
      fp    = 40'(w3_ff * p_ff2);
      f_in  = 18'(fp >>> 16);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff <= w1_in;
         w2_ff <= w2_in;
         p_ff  <= p_in;
         w3_ff <= w3_in;
         p_ff2 <= p_ff;
         f_ff  <= f_in;
         dly_ff[0] <= f_ff;
         for (int i = 1; i < DELAY; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign f = dly_ff[DELAY-1];

endmodule

// File: design/gradient_noise_2d_top.sv
// throughput: one sample per cycle, fully pipelined; every stage advances together
// and the whole pipe holds only while the response register is full and not taken
// hash multipliers, dot products and blend multiplies each sit in their own stage
// reset: synchronous, active high; clears all valid bits, payload is not reset
module gradient_noise_2d_top
   import gn2d_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // x_coord [31:0], y_coord [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // noise_value [15:0]
);

   localparam int SH_DN = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
   localparam int SH_UP = (COORD_FRAC_BITS >= 16) ? 0 : 16 - COORD_FRAC_BITS;
   localparam int STAGES = 1 + CORNER_LATENCY + 4;
   localparam logic [31:0] FRAC_MASK = 32'((64'd1 << COORD_FRAC_BITS) - 64'd1);

   logic en;
   logic [STAGES-1:0] vld_ff, vld_in;

   logic [31:0] x0_ff, y0_ff, x0_in, y0_in;
   logic [15:0] fx_ff, fy_ff, fx_in, fy_in;
   logic signed [17:0] dx0, dy0, dx1, dy1, sx, sy;
   logic signed [33:0] n00, n10, n01, n11;

   logic signed [34:0] d0, d1;
   logic signed [52:0] pr0_ff, pr1_ff, pr0_in, pr1_in;
   logic signed [33:0] a0_ff, a1_ff;
   logic signed [17:0] sy1_ff, sy2_ff;
   logic signed [35:0] row0_ff, row1_ff, row0_in, row1_in, row0b_ff;
   logic signed [36:0] dr;
   logic signed [54:0] py_ff, py_in;
   logic signed [38:0] acc;
   logic signed [22:0] val;
   logic [15:0] out_ff, out_in;

   assign en = !(vld_ff[STAGES-1] && !rsp_tready);
   assign req_tready = en;
   assign vld_in = {vld_ff[STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      x0_in = 32'($signed(req_tdata[31:0]) >>> COORD_FRAC_BITS);
      y0_in = 32'($signed(req_tdata[63:32]) >>> COORD_FRAC_BITS);
      fx_in = 16'(((req_tdata[31:0] & FRAC_MASK) >> SH_DN) << SH_UP);
      fy_in = 16'(((req_tdata[63:32] & FRAC_MASK) >> SH_DN) << SH_UP);
      dx0 = $signed({2'b00, fx_ff});
      dy0 = $signed({2'b00, fy_ff});
      dx1 = dx0 - ONE_Q16;
      dy1 = dy0 - ONE_Q16;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         fx_ff <= fx_in;
         fy_ff <= fy_in;
      end
   end

   gn2d_corner u_c00 (.clock(clock), .en(en), .cx(x0_ff), .cy(y0_ff),
      .dx(dx0), .dy(dy0), .dot(n00));
   gn2d_corner u_c10 (.clock(clock), .en(en), .cx(x0_ff + 32'd1), .cy(y0_ff),
      .dx(dx1), .dy(dy0), .dot(n10));
   gn2d_corner u_c01 (.clock(clock), .en(en), .cx(x0_ff), .cy(y0_ff + 32'd1),
      .dx(dx0), .dy(dy1), .dot(n01));
   gn2d_corner u_c11 (.clock(clock), .en(en), .cx(x0_ff + 32'd1), .cy(y0_ff + 32'd1),
      .dx(dx1), .dy(dy1), .dot(n11));

   gn2d_fade u_fx (.clock(clock), .en(en), .w(fx_ff), .f(sx));
   gn2d_fade u_fy (.clock(clock), .en(en), .w(fy_ff), .f(sy));

   always_comb begin
      d0 = 35'(n10) - 35'(n00);
      d1 = 35'(n11) - 35'(n01);
      pr0_in = 53'(sx * d0);
      pr1_in = 53'(sx * d1);
      row0_in = 36'(a0_ff) + 36'(pr0_ff >>> 16);
      row1_in = 36'(a1_ff) + 36'(pr1_ff >>> 16);
      dr = 37'(row1_ff) - 37'(row0_ff);
      py_in = 55'(sy2_ff * dr);
      acc = 39'(row0b_ff) + 39'(py_ff >>> 16);
      val = 23'(acc >>> 16);
      // saturate to q2.14
      if (val > 23'sd32767) begin
         out_in = 16'h7fff;
      end else if (val < -23'sd32768) begin
         out_in = 16'h8000;
      end else begin
         out_in = val[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr0_ff   <= pr0_in;
         pr1_ff   <= pr1_in;
         a0_ff    <= n00;
         a1_ff    <= n01;
         sy1_ff   <= sy;
         row0_ff  <= row0_in;
         row1_ff  <= row1_in;
         sy2_ff   <= sy1_ff;
         py_ff    <= py_in;
         row0b_ff <= row0_ff;
         out_ff   <= out_in;
      end
   end

   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = out_ff;

endmodule

// File: design/gn2d_checker.sv
// port-level checks for the gradient noise block
module gn2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // the pipe only holds while a response waits
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request side stalled without a waiting response");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("waiting response changed");

   assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // a taken response never holds the request side
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |-> req_tready)
      else $error("response taken while request side held");

endmodule

bind gradient_noise_2d_top gn2d_checker u_gn2d_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// File: test/gradient_noise_2d_top_test.sv
// self-checking testbench for the 2d gradient noise block with random stimulus and stalls
module gradient_noise_2d_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 16;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CALM_TAIL = 200;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic signed [31:0] y_coord;
      logic signed [31:0] x_coord;
   } point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   point_type   pending_points[$];
   logic [15:0] expected_noise[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_gap = 0;
   int          take_gap = 0;
   bit          stimulus_done = 1'b0;
   bit          calm = 1'b0;

   gradient_noise_2d_top #(.COORD_FRAC_BITS(FRAC_BITS)) dut (.*);

   always #1 clock = ~clock;

   function automatic logic signed [63:0] asr(input logic signed [63:0] v, input int s);
      return v >>> s;
   endfunction

   function automatic logic signed [63:0] quarter_wave_sine(input logic [7:0] idx);
      logic [15:0] table_row [0:64];
      table_row = '{0, 401, 804, 1206, 1606, 2005, 2404, 2802,
         3197, 3590, 3981, 4370, 4756, 5140, 5520, 5897,
         6270, 6639, 7006, 7366, 7723, 8076, 8423, 8765,
         9103, 9434, 9760, 10079, 10394, 10702, 11004, 11297,
         11585, 11865, 12141, 12406, 12665, 12916, 13160, 13396,
         13623, 13843, 14053, 14256, 14449, 14634, 14811, 14978,
         15137, 15286, 15426, 15557, 15678, 15791, 15892, 15986,
         16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379, 16384};
      if (idx <= 64) return table_row[idx];
      if (idx <= 128) return table_row[128 - idx];
      if (idx <= 192) return -table_row[idx - 128];
      return -table_row[256 - idx];
   endfunction

   function automatic logic [31:0] scramble(input logic [31:0] a);
      a = a ^ (a >> 16);
      a = a * 32'h7feb352d;
      a = a ^ (a >> 15);
      a = a * 32'h846ca68b;
      return a ^ (a >> 16);
   endfunction

   function automatic logic signed [63:0] corner_gradient_dot(input logic [31:0] cx,
         input logic [31:0] cy, input logic signed [63:0] dx, input logic signed [63:0] dy);
      logic [31:0] t;
      logic [31:0] h;
      t = cx ^ ((~(cx << cy[1:0])) * cy);
      h = scramble(scramble(t));
      return dx * quarter_wave_sine(8'(32'd64 - h)) + dy * quarter_wave_sine(h[7:0]);
   endfunction

   function automatic logic signed [63:0] quintic_fade(input logic signed [63:0] w);
      logic signed [63:0] w2, w3, p;
      w2 = asr(w * w, 16);
      w3 = asr(w2 * w, 16);
      p = asr(w * (6 * w - 15 * 65536), 16) + 10 * 65536;
      return asr(w3 * p, 16);
   endfunction

   function automatic logic signed [63:0] lerp_q16(input logic signed [63:0] a,
         input logic signed [63:0] b, input logic signed [63:0] f);
      return a + asr(f * (b - a), 16);
   endfunction

   function automatic logic [15:0] predict_noise(input point_type pt);
      logic [31:0] x0, y0, x1, y1;
      logic signed [63:0] fx, fy, n00, n10, n01, n11, sx, sy, val;
      x0 = 32'(asr(64'(pt.x_coord), FRAC_BITS));
      y0 = 32'(asr(64'(pt.y_coord), FRAC_BITS));
      fx = 64'(pt.x_coord[FRAC_BITS-1:0]);
      fy = 64'(pt.y_coord[FRAC_BITS-1:0]);
      x1 = x0 + 1;
      y1 = y0 + 1;
      n00 = corner_gradient_dot(x0, y0, fx, fy);
      n10 = corner_gradient_dot(x1, y0, fx - 65536, fy);
      n01 = corner_gradient_dot(x0, y1, fx, fy - 65536);
      n11 = corner_gradient_dot(x1, y1, fx - 65536, fy - 65536);
      sx = quintic_fade(fx);
      sy = quintic_fade(fy);
      val = asr(lerp_q16(lerp_q16(n00, n10, sx), lerp_q16(n01, n11, sx), sy), 16);
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      return val[15:0];
   endfunction

   function automatic point_type random_point();
      point_type pt;
      case ($urandom_range(0, 3))
         0: begin
            pt.x_coord = $urandom;
            pt.y_coord = $urandom;
         end
         // small grid near the origin, both signs
         1: begin
            pt.x_coord = $urandom_range(0, 32'h000fffff) - 32'h00080000;
            pt.y_coord = $urandom_range(0, 32'h000fffff) - 32'h00080000;
         end
         // near the wrap edges of the corner range
         2: begin
            pt.x_coord = 32'h7fff0000 + $urandom_range(0, 32'h0001ffff);
            pt.y_coord = 32'h7fff0000 + $urandom_range(0, 32'h0001ffff);
         end
         default: begin
            pt.x_coord = {4'($urandom_range(0, 15)), 12'h0, 16'($urandom)};
            pt.y_coord = {16'($urandom), $urandom_range(0, 1) ? 16'h0000 : 16'hffff};
         end
      endcase
      return pt;
   endfunction

   initial begin
      point_type pt;
      int corners [8];
      corners = '{32'h00000000, 32'h0000ffff, 32'h00010000, 32'hffffffff,
                  32'h7fffffff, 32'h80000000, 32'h7fff0000, 32'h00008000};
      foreach (corners[i]) begin
         pt.x_coord = corners[i];
         pt.y_coord = corners[(i + 3) % 8];
         pending_points.push_back(pt);
         pt.y_coord = corners[i];
         pending_points.push_back(pt);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) pending_points.push_back(random_point());
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (req_tvalid && req_tready)
               expected_noise.push_back(predict_noise(point_type'(req_tdata)));
            calm <= pending_points.size() < CALM_TAIL;
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_points.size() > 0 &&
                  (pending_points.size() < CALM_TAIL || $urandom_range(0, 9) != 0)) begin
               req_tdata <= pending_points.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
               if (pending_points.size() > 0) send_gap <= $urandom_range(0, 5);
               else stimulus_done <= 1'b1;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_noise.size() == 0) begin
               $display("%0t: unexpected noise_value transaction %h", $time, rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = expected_noise.pop_front();
               if (want !== rsp_tdata) begin
                  $display("%0t: noise_value expected %h actual %h", $time, want, rsp_tdata);
                  error_count <= error_count + 1;
               end
            end
         end
         if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            take_gap <= $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      wait (stimulus_done && expected_noise.size() == 0 || cycle_count >= CYCLE_LIMIT);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         repeat (40) @(posedge clock);
         if (error_count == 0 && expected_noise.size() == 0) begin
            $display("Testbench completed without errors");
         end else begin
            $display("Testbench completed WITH ERRORS");
         end
         $finish;
      end
   end

endmodule

// File: sim.f
design/gn2d_pkg.sv
design/gn2d_corner.sv
design/gn2d_fade.sv
design/gradient_noise_2d_top.sv
design/gn2d_checker.sv
test/gradient_noise_2d_top_test.sv
